@@ design/bmf_pkg.sv @@
// Shared types and constants of the bipartite max-flow filler.
package bmf_pkg;

  localparam int AMT_W = 32;
  localparam int IDX_W = 3;
  localparam int ACT_W = 2;
  localparam int CFG_W = 4;

  localparam logic [ACT_W-1:0] ACT_ROW_SUPPLY = 2'd0;
  localparam logic [ACT_W-1:0] ACT_COL_DEMAND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FIXED_CELL = 2'd2;
  localparam logic [ACT_W-1:0] ACT_SOLVE      = 2'd3;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_INIT, S_POP, S_NB, S_NBMEM,
    S_AUGRD, S_AUGEV, S_EMRD, S_EMLD, S_EMOUT
  } bmf_state_t;

  typedef enum logic [2:0] {
    E_SRC_ROW, E_ROW_SRC, E_ROW_COL, E_COL_SNK, E_COL_ROW
  } bmf_edge_t;

endpackage

@@ design/bipartite_max_flow_filler_core.sv @@
// Top level of the bipartite max-flow filler: loader, Edmonds-Karp solver and cell emitter.
// Load requests (supply, demand, fixed cell) are accepted only while idle. A solve request
// first sweeps the cell flow memory, then runs searches that step through each examined
// neighbor, with an extra memory read per column-to-row edge and a pop step per dequeued
// vertex, plus a read and an evaluate step per path edge in each of the two augment passes.
// Emission reads, loads and offers each cell and holds it until the sink takes it. Reset
// (rst_n, synchronous) clears supplies, demands, flow sums and fixed marks and sets both size registers to 8.
module bipartite_max_flow_filler_core import bmf_pkg::*; #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // request in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // row_index[2:0], col_index[5:3], amount[37:6], zero pad
  input  logic [1:0]  in_tuser,   // action[1:0]
  // cells out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_row[2:0], out_col[5:3], cell_weight[37:6], zero pad
  output logic        out_tuser,  // is_fixed
  output logic        out_tlast,  // last_cell
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata
);

  localparam int NV_MAX = MAX_ROWS + MAX_COLS + 2;
  localparam int VW     = $clog2(NV_MAX);
  localparam int QW     = $clog2(NV_MAX + 1);
  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int AW     = CELLS > 1 ? $clog2(CELLS) : 1;
  localparam int RIW    = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int CIW    = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
  localparam int RW     = $clog2(MAX_ROWS + 1);
  localparam int CW     = $clog2(MAX_COLS + 1);
  localparam int KW     = $clog2((MAX_ROWS > MAX_COLS ? MAX_ROWS : MAX_COLS) + 2);

  function automatic logic [AW-1:0] cell_at(input logic [RIW-1:0] r, input logic [CIW-1:0] c);
    logic [31:0] t;
    t = 32'(r) * MAX_COLS + 32'(c);
    return t[AW-1:0];
  endfunction

  // Size register value zero means one; values above the maximum saturate.
  function automatic logic [RW-1:0] clamp_rows(input logic [CFG_W-1:0] v);
    if (v == '0) return RW'(1);
    if (32'(v) > MAX_ROWS) return RW'(MAX_ROWS);
    return RW'(v);
  endfunction

  function automatic logic [CW-1:0] clamp_cols(input logic [CFG_W-1:0] v);
    if (v == '0) return CW'(1);
    if (32'(v) > MAX_COLS) return CW'(MAX_COLS);
    return CW'(v);
  endfunction

  // Request fields.
  logic [ACT_W-1:0] in_action;
  logic [IDX_W-1:0] in_row, in_col;
  logic [AMT_W-1:0] in_amount;
  assign in_action = in_tuser;
  assign in_row    = in_tdata[2:0];
  assign in_col    = in_tdata[5:3];
  assign in_amount = in_tdata[37:6];

  bmf_state_t state_r, state_nxt;

  logic [CFG_W-1:0] rows_cfg_r, cols_cfg_r;
  logic [RW-1:0]    nm_r;
  logic [CW-1:0]    nn_r;
  logic [AMT_W-1:0] row_supply_r [MAX_ROWS];
  logic [AMT_W-1:0] col_demand_r [MAX_COLS];
  logic [AMT_W-1:0] srf_r [MAX_ROWS];
  logic [AMT_W-1:0] csf_r [MAX_COLS];
  logic [CELLS-1:0] fixed_mark_r;
  logic [NV_MAX-1:0] visited_r;
  logic [VW-1:0]    parent_r [NV_MAX];
  logic [VW-1:0]    queue_r [NV_MAX];
  logic [QW-1:0]    head_r, tail_r;
  logic [VW-1:0]    u_r, v_r, walk_r;
  logic [KW-1:0]    k_r;
  logic [AMT_W-1:0] f_r;
  logic             pass_r;
  logic [AW-1:0]    clr_r;
  logic [RIW-1:0]   ei_r;
  logic [CIW-1:0]   ej_r;
  logic [2:0]       out_row_r, out_col_r;
  logic [AMT_W-1:0] out_weight_r;
  logic             out_fixed_r, out_last_r;

  logic in_acc, out_acc;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_EMOUT);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = {2'b00, out_weight_r, out_col_r, out_row_r};
  assign out_tuser  = out_fixed_r;
  assign out_tlast  = out_last_r;

  logic [VW-1:0] nmv, nnv, sinkv, kv;
  assign nmv   = VW'(nm_r);
  assign nnv   = VW'(nn_r);
  assign sinkv = nmv + nnv + VW'(1);
  assign kv    = VW'(k_r);

  // Neighbor candidate of the vertex being expanded, in adjacency order.
  logic          nb_done, nb_skip;
  logic [VW-1:0] v_nb, u_m1, u_c, k_m1;
  assign u_m1 = u_r - VW'(1);
  assign u_c  = u_r - nmv - VW'(1);
  assign k_m1 = kv - VW'(1);

  always_comb begin
    nb_done = 1'b0;
    nb_skip = 1'b0;
    v_nb    = '0;
    if (u_r == '0) begin
      nb_done = (kv >= nmv);
      v_nb    = kv + VW'(1);
    end else if (u_r <= nmv) begin
      if (kv == '0) begin
        v_nb = '0;
      end else if (kv <= nnv) begin
        nb_skip = fixed_mark_r[cell_at(u_m1[RIW-1:0], k_m1[CIW-1:0])];
        v_nb    = nmv + kv;
      end else begin
        nb_done = 1'b1;
      end
    end else if (u_r < sinkv) begin
      if (kv == '0) begin
        v_nb = sinkv;
      end else if (kv <= nmv) begin
        nb_skip = fixed_mark_r[cell_at(k_m1[RIW-1:0], u_c[CIW-1:0])];
        v_nb    = kv;
      end else begin
        nb_done = 1'b1;
      end
    end else begin
      nb_done = 1'b1;
    end
  end

  // Edge decode shared by the search and the augment walk.
  logic [VW-1:0]    ea, eb, ri_v, ci_v;
  logic [RIW-1:0]   ri;
  logic [CIW-1:0]   ci;
  logic             a_row;
  bmf_edge_t        ekind;
  logic [AMT_W-1:0] eres;
  logic             einf;
  logic [AW-1:0]    ecell;
  logic [AMT_W-1:0] cf_rdata, fv_rdata;

  always_comb begin
    if (state_r == S_AUGRD || state_r == S_AUGEV) begin
      ea = parent_r[walk_r];
      eb = walk_r;
    end else if (state_r == S_NBMEM) begin
      ea = u_r;
      eb = v_r;
    end else begin
      ea = u_r;
      eb = v_nb;
    end
  end

  assign a_row = (ea != '0) && (ea <= nmv);
  assign ri_v  = a_row ? (ea - VW'(1)) : (eb - VW'(1));
  assign ci_v  = (!a_row && ea != '0) ? (ea - nmv - VW'(1)) : (eb - nmv - VW'(1));
  assign ri    = ri_v[RIW-1:0];
  assign ci    = ci_v[CIW-1:0];
  assign ecell = cell_at(ri, ci);

  always_comb begin
    einf = 1'b0;
    eres = '0;
    if (ea == '0) begin
      ekind = E_SRC_ROW;
      eres  = row_supply_r[ri] - srf_r[ri];
    end else if (a_row) begin
      if (eb == '0) begin
        ekind = E_ROW_SRC;
        eres  = srf_r[ri];
      end else begin
        ekind = E_ROW_COL;
        einf  = 1'b1;
      end
    end else if (eb == sinkv) begin
      ekind = E_COL_SNK;
      eres  = col_demand_r[ci] - csf_r[ci];
    end else begin
      ekind = E_COL_ROW;
      eres  = cf_rdata;
    end
  end

  logic ev_ok;
  assign ev_ok = !visited_r[eb] && (einf || eres != '0);

  // Memory ports.
  logic             cf_we;
  logic [AW-1:0]    cf_waddr, cf_raddr, em_addr;
  logic [AMT_W-1:0] cf_wdata;
  logic             fv_we;

  assign em_addr  = cell_at(ei_r, ej_r);
  assign cf_raddr = (state_r == S_EMRD) ? em_addr : ecell;
  assign fv_we    = in_acc && in_action == ACT_FIXED_CELL &&
                    32'(in_row) < MAX_ROWS && 32'(in_col) < MAX_COLS;

  always_comb begin
    cf_we    = 1'b0;
    cf_waddr = ecell;
    cf_wdata = '0;
    if (state_r == S_CLR) begin
      cf_we    = 1'b1;
      cf_waddr = clr_r;
    end else if (state_r == S_AUGEV && pass_r) begin
      if (ekind == E_ROW_COL) begin
        cf_we    = 1'b1;
        cf_wdata = cf_rdata + f_r;
      end else if (ekind == E_COL_ROW) begin
        cf_we    = 1'b1;
        cf_wdata = cf_rdata - f_r;
      end
    end
  end

  bmf_ram #(.DW(AMT_W), .DEPTH(CELLS)) u_cell_flow (
    .clk   (clk),
    .we    (cf_we),
    .waddr (cf_waddr),
    .wdata (cf_wdata),
    .raddr (cf_raddr),
    .rdata (cf_rdata)
  );

  bmf_ram #(.DW(AMT_W), .DEPTH(CELLS)) u_fixed_value (
    .clk   (clk),
    .we    (fv_we),
    .waddr (cell_at(RIW'(in_row), CIW'(in_col))),
    .wdata (in_amount),
    .raddr (em_addr),
    .rdata (fv_rdata)
  );

  logic em_last;
  assign em_last = (RW'(ei_r) == nm_r - RW'(1)) && (CW'(ej_r) == nn_r - CW'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc && in_action == ACT_SOLVE) state_nxt = S_CLR;
      S_CLR:   if (clr_r == AW'(CELLS - 1)) state_nxt = S_INIT;
      S_INIT:  state_nxt = S_POP;
      S_POP:   state_nxt = (head_r == tail_r) ? S_EMRD : S_NB;
      S_NB: begin
        if (nb_done) begin
          state_nxt = S_POP;
        end else if (nb_skip) begin
          state_nxt = S_NB;
        end else if (ekind == E_COL_ROW) begin
          state_nxt = S_NBMEM;
        end else if (ev_ok && eb == sinkv) begin
          state_nxt = S_AUGRD;
        end
      end
      S_NBMEM: state_nxt = S_NB;
      S_AUGRD: state_nxt = S_AUGEV;
      S_AUGEV: begin
        if (ea == '0 && pass_r) state_nxt = S_INIT;
        else state_nxt = S_AUGRD;
      end
      S_EMRD:  state_nxt = S_EMLD;
      S_EMLD:  state_nxt = S_EMOUT;
      S_EMOUT: if (out_acc) state_nxt = out_last_r ? S_IDLE : S_EMRD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r   <= CFG_W'(8);
      cols_cfg_r   <= CFG_W'(8);
      fixed_mark_r <= '0;
      visited_r    <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      for (int i = 0; i < MAX_ROWS; i++) begin
        row_supply_r[i] <= '0;
        srf_r[i]        <= '0;
      end
      for (int j = 0; j < MAX_COLS; j++) begin
        col_demand_r[j] <= '0;
        csf_r[j]        <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_ROWS) rows_cfg_r <= cfg_wdata;
        else cols_cfg_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_action)
              ACT_ROW_SUPPLY: if (32'(in_row) < MAX_ROWS) row_supply_r[RIW'(in_row)] <= in_amount;
              ACT_COL_DEMAND: if (32'(in_col) < MAX_COLS) col_demand_r[CIW'(in_col)] <= in_amount;
              ACT_FIXED_CELL: if (fv_we) fixed_mark_r[cell_at(RIW'(in_row), CIW'(in_col))] <= 1'b1;
              default: begin
                nm_r  <= clamp_rows(rows_cfg_r);
                nn_r  <= clamp_cols(cols_cfg_r);
                clr_r <= '0;
                for (int i = 0; i < MAX_ROWS; i++) srf_r[i] <= '0;
                for (int j = 0; j < MAX_COLS; j++) csf_r[j] <= '0;
              end
            endcase
          end
        end
        S_CLR: clr_r <= clr_r + AW'(1);
        S_INIT: begin
          visited_r    <= NV_MAX'(1);
          queue_r[0]   <= '0;
          head_r       <= '0;
          tail_r       <= QW'(1);
        end
        S_POP: begin
          if (head_r == tail_r) begin
            ei_r <= '0;
            ej_r <= '0;
          end else begin
            u_r    <= queue_r[head_r[VW-1:0]];
            k_r    <= '0;
            head_r <= head_r + QW'(1);
          end
        end
        S_NB: begin
          if (!nb_done) begin
            k_r <= k_r + KW'(1);
            v_r <= v_nb;
            if (!nb_skip && ekind != E_COL_ROW && ev_ok) begin
              visited_r[eb]             <= 1'b1;
              parent_r[eb]              <= u_r;
              queue_r[tail_r[VW-1:0]]   <= eb;
              tail_r                    <= tail_r + QW'(1);
              if (eb == sinkv) begin
                walk_r <= sinkv;
                f_r    <= '1;
                pass_r <= 1'b0;
              end
            end
          end
        end
        S_NBMEM: begin
          if (ev_ok) begin
            visited_r[eb]           <= 1'b1;
            parent_r[eb]            <= u_r;
            queue_r[tail_r[VW-1:0]] <= eb;
            tail_r                  <= tail_r + QW'(1);
          end
        end
        S_AUGEV: begin
          if (!pass_r) begin
            if (!einf && eres < f_r) f_r <= eres;
          end else begin
            case (ekind)
              E_SRC_ROW: srf_r[ri] <= srf_r[ri] + f_r;
              E_ROW_SRC: srf_r[ri] <= srf_r[ri] - f_r;
              E_COL_SNK: csf_r[ci] <= csf_r[ci] + f_r;
              default: ;
            endcase
          end
          if (ea == '0) begin
            walk_r <= sinkv;
            pass_r <= 1'b1;
          end else begin
            walk_r <= ea;
          end
        end
        S_EMLD: begin
          out_row_r    <= 3'(ei_r);
          out_col_r    <= 3'(ej_r);
          out_fixed_r  <= fixed_mark_r[em_addr];
          out_weight_r <= fixed_mark_r[em_addr] ? fv_rdata : cf_rdata;
          out_last_r   <= em_last;
        end
        S_EMOUT: begin
          if (out_acc) begin
            if (out_last_r) begin
              fixed_mark_r <= '0;
            end else if (CW'(ej_r) == nn_r - CW'(1)) begin
              ej_r <= '0;
              ei_r <= ei_r + RIW'(1);
            end else begin
              ej_r <= ej_r + CIW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // The loader and the emitter never run at the same time.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("request and cell channels both active");

  // Each vertex enters the search queue at most once.
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= QW'(NV_MAX)) else $error("search queue overflow");

  a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r) else $error("search queue read past its tail");

  // After the final cell is taken the block is ready for the next request.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (in_tready && fixed_mark_r == '0))
    else $error("block not idle after final cell");

endmodule

@@ design/bmf_ram.sv @@
// Single write port, single registered read port memory.
module bmf_ram import bmf_pkg::*; #(
  parameter int DW    = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DW-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DW-1:0]                          rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
